### src/button_press_classifier_assert.svh
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define BPC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned CFG_W           = 16;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned PHASE_W         = 3;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned COUNT_W_DEFAULT = 16;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_W-1:0] HOLD_GAP_RST = 16'd50;
  localparam logic [CFG_W-1:0] REPEAT_RST   = 16'd10;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd100;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE      = 3'd0,
    PH_DEBOUNCE  = 3'd1,
    PH_CHECK     = 3'd2,
    PH_GAP       = 3'd3,
    PH_HOLD_WAIT = 3'd4,
    PH_REPEAT    = 3'd5,
    PH_RELEASE   = 3'd6
  } bpc_phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_HOLD_GAP = 2'd1,
    CFG_REPEAT   = 2'd2,
    CFG_HOLD     = 2'd3
  } bpc_cfg_e;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
  } bpc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } bpc_sts_t;

endpackage

### src/bpc_in_if.sv
interface bpc_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

### src/bpc_out_if.sv
interface bpc_out_if import bpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               single_pulse;
  logic               hold_pulse;
  logic               repeat_pulse;
  logic [PHASE_W-1:0] phase;
  logic [TICK_W-1:0]  tick_count;

  modport source (output valid, output single_pulse, output hold_pulse, output repeat_pulse,
                  output phase, output tick_count, input ready);
  modport sink   (input valid, input single_pulse, input hold_pulse, input repeat_pulse,
                  input phase, input tick_count, output ready);
endinterface

### src/bpc_rem.sv
module bpc_rem import bpc_pkg::*; #(
  parameter int unsigned DVD_W = COUNT_W_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [CFG_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   dsr_ext;

  // restoring remainder, one dividend bit per cycle
  assign trial   = {r_q, dvd_q[DVD_W-1]};
  assign dsr_ext = {1'b0, divisor_i};
  assign r_d     = (trial >= dsr_ext) ? CFG_W'(trial - dsr_ext) : CFG_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DVD_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      r_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      r_q   <= r_d;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = DVD_W'(r_q);

endmodule

### src/bpc_ctrl.sv
module bpc_ctrl import bpc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bpc_sts_t sts_i,
  output bpc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_COMMIT
  } ctrl_state_e;

  ctrl_state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= sts_i.need_div ? S_DIV : S_COMMIT;
        end
        S_DIV: begin
          if (sts_i.div_done) state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start = (state_q == S_EVAL) && sts_i.need_div;
    cmd_o.commit    = (state_q == S_COMMIT) && sts_i.out_free;
  end

endmodule

### src/bpc_dp.sv
module bpc_dp import bpc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 level_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 single_pulse_o,
  output logic                 hold_pulse_o,
  output logic                 repeat_pulse_o,
  output logic [PHASE_W-1:0]   phase_o,
  output logic [TICK_W-1:0]    tick_count_o,
  input  bpc_cmd_t             cmd_i,
  output bpc_sts_t             sts_o
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic [CFG_W-1:0]       deb_q, gap_q, per_q, hold_q;
  bpc_phase_e             ph_q, ph_d;
  logic [COUNT_WIDTH-1:0] c_q, c_d, c_inc, rem, rem_sel;
  logic                   level_q;
  logic                   out_valid_q;
  logic                   single_d, hold_d, rep_d;
  logic                   single_pulse_q, hold_pulse_q, repeat_pulse_q;
  logic [PHASE_W-1:0]     phase_q;
  logic [TICK_W-1:0]      tick_count_q;
  logic                   div_busy;
  logic [CMP_W-1:0]       c_ext;
  logic                   lt_deb, lt_gap, lt_per, lt_hold;

  bpc_rem #(.DVD_W(COUNT_WIDTH)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (c_q),
    .divisor_i  (per_q),
    .busy_o     (div_busy),
    .rem_o      (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q  <= DEBOUNCE_RST;
      gap_q  <= HOLD_GAP_RST;
      per_q  <= REPEAT_RST;
      hold_q <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (bpc_cfg_e'(cfg_idx_i))
        CFG_DEBOUNCE: deb_q  <= cfg_data_i;
        CFG_HOLD_GAP: gap_q  <= cfg_data_i;
        CFG_REPEAT:   per_q  <= cfg_data_i;
        CFG_HOLD:     hold_q <= cfg_data_i;
        default:      deb_q  <= deb_q;
      endcase
    end
  end

  assign c_ext   = CMP_W'(c_q);
  assign lt_deb  = c_ext < CMP_W'(deb_q);
  assign lt_gap  = c_ext < CMP_W'(gap_q);
  assign lt_per  = c_ext < CMP_W'(per_q);
  assign lt_hold = c_ext < CMP_W'(hold_q);
  assign c_inc   = c_q + 1'b1;
  // zero period: remainder taken as the dividend
  assign rem_sel = (per_q == '0) ? c_q : rem;

  always_comb begin
    ph_d     = ph_q;
    c_d      = c_q;
    single_d = 1'b0;
    hold_d   = 1'b0;
    rep_d    = 1'b0;
    unique case (ph_q)
      PH_DEBOUNCE: begin
        if (lt_deb) begin
          c_d = c_inc;
        end else begin
          c_d  = '0;
          ph_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        c_d = '0;
        if (!level_q) begin
          single_d = 1'b1;
          ph_d     = PH_RELEASE;
        end else begin
          ph_d = PH_GAP;
        end
      end
      PH_GAP: begin
        if (!level_q) begin
          single_d = 1'b1;
          c_d      = '0;
          ph_d     = PH_RELEASE;
        end else if (lt_gap) begin
          c_d = c_inc;
        end else begin
          c_d  = '0;
          ph_d = PH_HOLD_WAIT;
        end
      end
      PH_HOLD_WAIT: begin
        if (!level_q) begin
          single_d = 1'b1;
          c_d      = '0;
          ph_d     = PH_RELEASE;
        end else if (lt_hold) begin
          c_d = c_inc;
        end else begin
          hold_d = 1'b1;
          c_d    = rem_sel + 1'b1;
          ph_d   = PH_REPEAT;
        end
      end
      PH_REPEAT: begin
        if (!level_q) begin
          c_d  = '0;
          ph_d = PH_RELEASE;
        end else if (lt_per) begin
          c_d = c_inc;
        end else begin
          rep_d = 1'b1;
          c_d   = '0;
        end
      end
      PH_RELEASE: begin
        if (lt_deb) begin
          c_d = c_inc;
        end else begin
          c_d  = '0;
          ph_d = PH_IDLE;
        end
      end
      default: begin
        ph_d = PH_IDLE;
        if (level_q) begin
          c_d  = '0;
          ph_d = PH_DEBOUNCE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      c_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        ph_q <= ph_d;
        c_q  <= c_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) level_q <= level_i;
    if (cmd_i.commit) begin
      single_pulse_q <= single_d;
      hold_pulse_q   <= hold_d;
      repeat_pulse_q <= rep_d;
      phase_q        <= PHASE_W'(ph_d);
      tick_count_q   <= TICK_W'(c_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign single_pulse_o = single_pulse_q;
  assign hold_pulse_o   = hold_pulse_q;
  assign repeat_pulse_o = repeat_pulse_q;
  assign phase_o        = phase_q;
  assign tick_count_o   = tick_count_q;
  assign sts_o.need_div = (ph_q == PH_HOLD_WAIT) && level_q && !lt_hold;
  assign sts_o.div_done = !div_busy;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

### src/button_press_classifier.sv
// channel  dir  modport            payload
// btn_i    in   bpc_in_if.sink     button_level
// evt_o    out  bpc_out_if.source  single_pulse, hold_pulse, repeat_pulse, phase, tick_count
//
// A beat passes through accept, evaluate and commit into the output register.
// On hold entry the bit-serial remainder unit runs between evaluate and commit.
// Reset clears phase, counter and output valid, and loads register defaults.
// The next beat is taken while a result waits in the output register; commit
// stalls until that register is free.
module button_press_classifier import bpc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_W_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bpc_in_if.sink               btn_i,
  bpc_out_if.source            evt_o
);

  `include "button_press_classifier_assert.svh"

  bpc_cmd_t cmd;
  bpc_sts_t sts;

  bpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (btn_i.valid),
    .in_ready_o (btn_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpc_dp #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .level_i        (btn_i.button_level),
    .out_ready_i    (evt_o.ready),
    .out_valid_o    (evt_o.valid),
    .single_pulse_o (evt_o.single_pulse),
    .hold_pulse_o   (evt_o.hold_pulse),
    .repeat_pulse_o (evt_o.repeat_pulse),
    .phase_o        (evt_o.phase),
    .tick_count_o   (evt_o.tick_count),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

  `BPC_CHECK(a_commit_free, cmd.commit, sts.out_free, "commit into a full output register")
  `BPC_CHECK(a_div_needed, cmd.div_start, sts.need_div, "remainder started without hold entry")
  `BPC_CHECK_NEXT(a_commit_shows, cmd.commit, evt_o.valid, "committed result not presented")
  `BPC_CHECK(a_no_overlap, cmd.capture, !cmd.commit && !cmd.div_start, "capture during work")

endmodule
